// ===== rtl/jbr_pkg.sv =====
`default_nettype none

package jbr_pkg;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int THR_W      = 12;
  localparam int VAL_W      = 16;
  localparam int WIDE_W     = 16;

  // shared multiplier: DIV_W-bit by RCP_W-bit operands
  localparam int DIV_W  = 26;
  localparam int RCP_W  = 27;
  localparam int PROD_W = DIV_W + RCP_W;

  localparam int                MILLE_W   = 10;
  localparam logic [MILLE_W-1:0] MILLE    = 10'd1000;
  localparam logic [DIV_W-1:0]   CEIL_BIAS = 26'd999;
  localparam logic [VAL_W-1:0]   VAL_MAX   = 16'hFFFF;

  // ceil(2^36 / 1000): exact floor division by 1000 for any DIV_W-bit value
  localparam int                 MILLE_SHIFT = 36;
  localparam logic [RCP_W-1:0]   MILLE_RCP   = 27'd68719477;

  typedef enum logic [1:0] {
    MODE_WATCH = 2'd0,
    MODE_PRESS = 2'd1,
    MODE_WAIT  = 2'd2
  } mode_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_LEFT_ABOVE  = 3'd0,
    REG_RIGHT_BELOW = 3'd1,
    REG_PRESS_MS    = 3'd2,
    REG_REPEAT_MIN  = 3'd3,
    REG_REPEAT_MAX  = 3'd4
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EVAL,
    ST_MUL1,
    ST_DIV1,
    ST_MUL2,
    ST_BIAS,
    ST_DIV2,
    ST_UPDATE,
    ST_DONE
  } seq_t;

  typedef struct packed {
    logic [THR_W-1:0] left_above;
    logic [THR_W-1:0] right_below;
    logic [VAL_W-1:0] press_ms;
    logic [VAL_W-1:0] repeat_min_ms;
    logic [VAL_W-1:0] repeat_max_ms;
  } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/jbr_if.sv =====
`default_nettype none

interface jbr_in_if #(
  parameter int SAMPLE_BITS = 12
) ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface jbr_out_if ();
  logic       valid;
  logic       ready;
  logic       left_press;
  logic       right_press;
  logic [1:0] phase;

  modport source (output valid, output left_press, output right_press, output phase,
                  input ready);
  modport sink   (input valid, input left_press, input right_press, input phase,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/jbr_cfg.sv =====
`default_nettype none

module jbr_cfg
  import jbr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  we,
  input  wire logic [CFG_ADDR_W-1:0] addr,
  input  wire logic [CFG_DATA_W-1:0] wdata,
  output cfg_t                       cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.left_above    <= 12'd2457;
      cfg.right_below   <= 12'd1638;
      cfg.press_ms      <= 16'd50;
      cfg.repeat_min_ms <= 16'd100;
      cfg.repeat_max_ms <= 16'd500;
    end else if (we) begin
      unique case (addr)
        REG_LEFT_ABOVE:  cfg.left_above    <= wdata[THR_W-1:0];
        REG_RIGHT_BELOW: cfg.right_below   <= wdata[THR_W-1:0];
        REG_PRESS_MS:    cfg.press_ms      <= wdata[VAL_W-1:0];
        REG_REPEAT_MIN:  cfg.repeat_min_ms <= wdata[VAL_W-1:0];
        REG_REPEAT_MAX:  cfg.repeat_max_ms <= wdata[VAL_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/jbr_div.sv =====
`default_nettype none

module jbr_div
  import jbr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              start,
  input  wire logic [DIV_W-1:0]  a,
  input  wire logic [RCP_W-1:0]  b,
  output logic [PROD_W-1:0]      prod
);

  // shared multiplier; a divide by a constant is a multiply by its rounded-up
  // reciprocal, the quotient being an upper slice of the product
  always_ff @(posedge clk) begin
    if (start) prod <= PROD_W'(a) * PROD_W'(b);
  end

endmodule

`default_nettype wire

// ===== rtl/joystick_to_button_repeater.sv =====
// Joystick-to-button repeater.
// samples: one beat per 1 ms tick carrying a joystick converter reading.
// buttons: one beat per accepted sample with left_press, right_press and
//   phase (0 watching, 1 pressing, 2 waiting), showing the state after it.
// cfg_we/cfg_addr/cfg_wdata: register writes (0 left_above, 1 right_below,
//   2 press_ms, 3 repeat_min_ms, 4 repeat_max_ms); other indexes are dropped.
//   Write only while no sample is in flight.
// One sample at a time. A tick that needs no repeat time goes from the
// evaluation straight to the update. A waiting tick on the stored side computes
// the repeat time on one shared multiplier: two products and two constant
// divisions done as reciprocal multiplications, plus a rounding step, in the
// order product, division, product, rounding, division.
// samples.ready rises again once the result is in the output register, so a
// new sample is taken while the previous result waits; a stalled receiver
// holds that result and the next one waits in the sequencer until the
// register frees.
// Reset (rst, synchronous) restores the register defaults, returns to
// watching with no button pressed and empties the output register.
`default_nettype none

module joystick_to_button_repeater
  import jbr_pkg::*;
#(
  parameter int SAMPLE_BITS = 12
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  jbr_in_if.sink                     samples,
  jbr_out_if.source                  buttons,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int FULL       = (1 << SAMPLE_BITS) - 1;
  // ceil(2^FULL_SHIFT / FULL): exact floor division by FULL for any
  // DIV_W-bit value
  localparam int FULL_SHIFT = DIV_W + SAMPLE_BITS;
  localparam longint unsigned FULL_RCP_L =
    ((64'd1 << FULL_SHIFT) + 64'(FULL) - 64'd1) / 64'(FULL);
  localparam logic [RCP_W-1:0] FULL_RCP = RCP_W'(FULL_RCP_L);

  cfg_t cfg;

  seq_t state, state_next;

  mode_t            mode, mode_next;
  logic             went_left, went_left_next;
  logic [VAL_W-1:0] elapsed, elapsed_next;

  logic [SAMPLE_BITS-1:0] s;
  logic [SAMPLE_BITS-1:0] mirror;
  logic [WIDE_W-1:0]      dist2;
  logic [WIDE_W-1:0]      s_wide;
  logic                   side;

  logic [PROD_W-1:0]  prod;
  logic [DIV_W-1:0]   mul_a;
  logic [RCP_W-1:0]   mul_b;
  logic               mul_en;
  logic [DIV_W-1:0]   num;
  logic               num_load;
  logic [MILLE_W-1:0] x;
  logic [VAL_W-1:0]   quo;

  logic              asc;
  logic [VAL_W-1:0]  span;
  logic [VAL_W-1:0]  rep;
  logic [VAL_W-1:0]  elapsed_inc;

  logic upd_en;
  logic out_load;

  logic       out_valid;
  logic       out_left;
  logic       out_right;
  logic [1:0] out_phase;

  jbr_cfg u_cfg (
    .clk   (clk),
    .rst   (rst),
    .we    (cfg_we),
    .addr  (cfg_addr),
    .wdata (cfg_wdata),
    .cfg   (cfg)
  );

  jbr_div u_div (
    .clk   (clk),
    .start (mul_en),
    .a     (mul_a),
    .b     (mul_b),
    .prod  (prod)
  );

  // FULL - |FULL - 2s| equals 2*min(s, FULL-s); FULL-s is ~s
  assign side   = s[SAMPLE_BITS-1];
  assign mirror = side ? ~s : s;
  assign dist2  = WIDE_W'({mirror[SAMPLE_BITS-2:0], 1'b0});
  assign s_wide = WIDE_W'(s);

  assign x   = prod[FULL_SHIFT +: MILLE_W];
  assign quo = prod[MILLE_SHIFT +: VAL_W];

  assign asc  = cfg.repeat_max_ms >= cfg.repeat_min_ms;
  assign span = asc ? cfg.repeat_max_ms - cfg.repeat_min_ms
                    : cfg.repeat_min_ms - cfg.repeat_max_ms;
  assign rep  = asc ? cfg.repeat_min_ms + quo
                    : cfg.repeat_min_ms - quo;

  assign elapsed_inc = (elapsed == VAL_MAX) ? VAL_MAX : elapsed + 1'b1;

  assign samples.ready = (state == ST_IDLE);

  // sequencer: next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (samples.valid) state_next = ST_EVAL;
      ST_EVAL:   state_next = (mode == MODE_WAIT && side == went_left) ? ST_MUL1 : ST_UPDATE;
      ST_MUL1:   state_next = ST_DIV1;
      ST_DIV1:   state_next = ST_MUL2;
      ST_MUL2:   state_next = ST_BIAS;
      ST_BIAS:   state_next = ST_DIV2;
      ST_DIV2:   state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_DONE;
      ST_DONE:   if (!out_valid || buttons.ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // sequencer: controls for the shared multiplier, the rounding register, the tick update and the output register
  always_comb begin
    mul_en   = 1'b0;
    mul_a    = DIV_W'(dist2);
    mul_b    = RCP_W'(MILLE);
    num_load = 1'b0;
    upd_en   = 1'b0;
    out_load = 1'b0;
    unique case (state)
      ST_MUL1: mul_en = 1'b1;
      ST_DIV1: begin
        mul_en = 1'b1;
        mul_a  = prod[DIV_W-1:0];
        mul_b  = FULL_RCP;
      end
      ST_MUL2: begin
        mul_en = 1'b1;
        mul_a  = DIV_W'(span);
        mul_b  = RCP_W'(x);
      end
      ST_BIAS: num_load = 1'b1;
      ST_DIV2: begin
        mul_en = 1'b1;
        mul_a  = num;
        mul_b  = MILLE_RCP;
      end
      ST_UPDATE: upd_en = 1'b1;
      ST_DONE: out_load = !out_valid || buttons.ready;
      default: ;
    endcase
  end

  // tick update
  always_comb begin
    mode_next      = mode;
    went_left_next = went_left;
    elapsed_next   = elapsed;
    unique case (mode)
      MODE_PRESS: begin
        elapsed_next = elapsed_inc;
        if (elapsed_inc >= cfg.press_ms) begin
          elapsed_next = '0;
          mode_next    = MODE_WAIT;
        end
      end
      MODE_WAIT: begin
        if (side != went_left) begin
          mode_next = MODE_WATCH;
        end else begin
          elapsed_next = elapsed_inc;
          if (elapsed_inc >= rep) mode_next = MODE_WATCH;
        end
      end
      default: begin
        mode_next = MODE_WATCH;
        if (s_wide > WIDE_W'(cfg.left_above)) begin
          went_left_next = 1'b1;
          elapsed_next   = '0;
          mode_next      = MODE_PRESS;
        end else if (s_wide < WIDE_W'(cfg.right_below)) begin
          went_left_next = 1'b0;
          elapsed_next   = '0;
          mode_next      = MODE_PRESS;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (samples.valid && samples.ready) s <= samples.sample;
    // round toward minus infinity when the wait shrinks below the minimum
    if (num_load) num <= asc ? prod[DIV_W-1:0] : prod[DIV_W-1:0] + CEIL_BIAS;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_WATCH;
      went_left <= 1'b0;
      elapsed   <= '0;
    end else if (upd_en) begin
      mode      <= mode_next;
      went_left <= went_left_next;
      elapsed   <= elapsed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst)               out_valid <= 1'b0;
    else if (out_load)     out_valid <= 1'b1;
    else if (buttons.ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_left  <= (mode == MODE_PRESS) && went_left;
      out_right <= (mode == MODE_PRESS) && !went_left;
      out_phase <= mode;
    end
  end

  assign buttons.valid       = out_valid;
  assign buttons.left_press  = out_left;
  assign buttons.right_press = out_right;
  assign buttons.phase       = out_phase;

  a_hold_out: assert property (@(posedge clk) disable iff (rst)
    (buttons.valid && !buttons.ready) |=>
      (buttons.valid && $stable({buttons.left_press, buttons.right_press, buttons.phase})))
    else $error("result changed while stalled");

  a_one_button: assert property (@(posedge clk) disable iff (rst)
    buttons.valid |-> !(buttons.left_press && buttons.right_press))
    else $error("both buttons pressed");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (samples.valid && samples.ready) |=> !samples.ready)
    else $error("second sample taken while one is in flight");

  a_load_done: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (state == ST_DONE && state_next == ST_IDLE))
    else $error("result loaded outside the done step");

endmodule

`default_nettype wire
